FILE: rtl/frame_parser_crc16_check_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame parser with CRC-16 check
// ---------------------------------------------------------------------------
`ifndef FRAME_PARSER_CRC16_CHECK_CORE_DEFINES_SVH
`define FRAME_PARSER_CRC16_CHECK_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted
`define FPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent assertion that is also checked while reset is asserted
`define FPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/fpc_pkg.sv
// ---------------------------------------------------------------------------
// fpc_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update.
// ---------------------------------------------------------------------------
package fpc_pkg;

  // Frame layout
  localparam int HEADER_BYTES = 18;
  localparam int CRC_BYTES    = 2;
  localparam int POS_W        = 17;
  localparam int SPAN_W       = POS_W + 1;
  localparam int LEN_W        = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register reset values
  localparam logic [7:0]       MAGIC_FIRST_RST  = 8'h00;
  localparam logic [7:0]       MAGIC_SECOND_RST = 8'h00;
  localparam logic [7:0]       VERSION_RST      = 8'h01;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST  = 16'd1024;

  typedef enum logic [1:0] {
    CFG_MAGIC_FIRST  = 2'd0,
    CFG_MAGIC_SECOND = 2'd1,
    CFG_VERSION      = 2'd2,
    CFG_MAX_PAYLOAD  = 2'd3
  } fpc_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_TOOLONG  = 3'd4,
    ST_LENGTH   = 3'd5,
    ST_CRC      = 3'd6
  } fpc_status_e;

  typedef struct packed {
    logic [7:0]       magic_first;
    logic [7:0]       magic_second;
    logic [7:0]       expected_version;
    logic [LEN_W-1:0] max_payload;
  } fpc_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } fpc_item_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    fpc_status_e      status;
    logic [7:0]       msg_type;
    logic [7:0]       frame_flags;
    logic [7:0]       reserved_byte;
    logic [31:0]      session_number;
    logic [LEN_W-1:0] chunk_number;
    logic [LEN_W-1:0] chunk_total;
    logic [LEN_W-1:0] payload_size;
  } fpc_result_t;

  // Advance the CRC by one byte, MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/fpc_cfg.sv
// ---------------------------------------------------------------------------
// fpc_cfg
// Configuration registers, written through a plain index/data port.
// ---------------------------------------------------------------------------
module fpc_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  output fpc_pkg::fpc_cfg_t cfg_o
);
  import fpc_pkg::*;

  fpc_cfg_t cfg_q, cfg_d;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (fpc_cfg_idx_e'(cfg_index_i))
        CFG_MAGIC_FIRST:  cfg_d.magic_first      = cfg_data_i[7:0];
        CFG_MAGIC_SECOND: cfg_d.magic_second     = cfg_data_i[7:0];
        CFG_VERSION:      cfg_d.expected_version = cfg_data_i[7:0];
        CFG_MAX_PAYLOAD:  cfg_d.max_payload      = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_first      <= MAGIC_FIRST_RST;
      cfg_q.magic_second     <= MAGIC_SECOND_RST;
      cfg_q.expected_version <= VERSION_RST;
      cfg_q.max_payload      <= MAX_PAYLOAD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/fpc_in_stage.sv
// ---------------------------------------------------------------------------
// fpc_in_stage
// Input register: holds one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module fpc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_frame_i,
  input  logic               free_i,
  output logic               step_o,
  output fpc_pkg::fpc_item_t item_o
);
  import fpc_pkg::*;

  logic      valid_q, valid_d;
  fpc_item_t item_q;
  logic      load;

  // Hold the byte while the result side is blocked
  assign step_o     = valid_q & free_i;
  assign in_stall_o = valid_q & ~free_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte    <= data_byte_i;
      item_q.end_of_frame <= end_of_frame_i;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/fpc_parse.sv
// ---------------------------------------------------------------------------
// fpc_parse
// Per-frame state: byte position, header capture, CRC and frame status.
// ---------------------------------------------------------------------------
module fpc_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpc_pkg::fpc_cfg_t    cfg_i,
  input  logic                 step_i,
  input  fpc_pkg::fpc_item_t   item_i,
  output logic                 res_valid_o,
  output fpc_pkg::fpc_result_t res_o
);
  import fpc_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  fpc_status_e      herr_q, herr_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       flags_q, flags_d;
  logic [7:0]       resv_q, resv_d;
  logic [31:0]      sess_q, sess_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [15:0]      rcrc_q, rcrc_d;

  logic [7:0]       b;
  logic [SPAN_W-1:0] pos_ext;
  logic [SPAN_W-1:0] body_end;
  logic [SPAN_W-1:0] frame_total;
  logic [POS_W-1:0] count;
  logic             in_body;
  fpc_status_e      status;

  assign b = item_i.data_byte;

  // Capture header bytes and run the checks for this byte
  always_comb begin
    herr_d  = herr_q;
    type_d  = type_q;
    flags_d = flags_q;
    resv_d  = resv_q;
    sess_d  = sess_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    case (pos_q)
      17'd0:  if (b != cfg_i.magic_first && herr_q == ST_OK) herr_d = ST_MAGIC;
      17'd1:  if (b != cfg_i.magic_second && herr_q == ST_OK) herr_d = ST_MAGIC;
      17'd2:  if (b != cfg_i.expected_version && herr_q == ST_OK) herr_d = ST_VERSION;
      17'd3:  type_d  = b;
      17'd4:  flags_d = b;
      17'd5:  resv_d  = b;
      17'd6:  sess_d[7:0]   = b;
      17'd7:  sess_d[15:8]  = b;
      17'd8:  sess_d[23:16] = b;
      17'd9:  sess_d[31:24] = b;
      17'd10: idx_d[7:0]    = b;
      17'd11: idx_d[15:8]   = b;
      17'd12: cnt_d[7:0]    = b;
      17'd13: cnt_d[15:8]   = b;
      17'd14: len_d[7:0]    = b;
      17'd15: begin
        len_d[15:8] = b;
        if ({b, len_q[7:0]} > cfg_i.max_payload && herr_q == ST_OK) begin
          herr_d = ST_TOOLONG;
        end
      end
      default: herr_d = herr_q;
    endcase
  end

  // Advance CRC, trailer shift and saturating position
  always_comb begin
    pos_ext     = {1'b0, pos_q};
    body_end    = SPAN_W'(HEADER_BYTES) + {2'b00, len_d};
    frame_total = body_end + SPAN_W'(CRC_BYTES);
    in_body     = (pos_ext >= SPAN_W'(HEADER_BYTES)) && (pos_ext < body_end);
    crc_d       = (pos_ext < body_end) ? crc_byte(crc_q, b) : crc_q;
    rcrc_d      = {b, rcrc_q[15:8]};
    count       = (pos_q == POS_MAX) ? POS_MAX : pos_q + POS_W'(1);
    pos_d       = count;
  end

  // Pick the frame status in check order
  always_comb begin
    if ({1'b0, count} < SPAN_W'(HEADER_BYTES + CRC_BYTES)) begin
      status = ST_SHORT;
    end else if (herr_d != ST_OK) begin
      status = herr_d;
    end else if ({1'b0, count} != frame_total) begin
      status = ST_LENGTH;
    end else if (rcrc_d != crc_d) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  // Build the result for this byte
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (item_i.end_of_frame) begin
      res_valid_o          = step_i;
      res_o.kind           = 1'b1;
      res_o.status         = status;
      res_o.msg_type       = type_d;
      res_o.frame_flags    = flags_d;
      res_o.reserved_byte  = resv_d;
      res_o.session_number = sess_d;
      res_o.chunk_number   = idx_d;
      res_o.chunk_total    = cnt_d;
      res_o.payload_size   = len_d;
    end else begin
      res_valid_o        = step_i && (herr_q == ST_OK) && in_body;
      res_o.payload_byte = b;
    end
  end

  // Update frame state, clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CRC_INIT;
      herr_q  <= ST_OK;
      type_q  <= '0;
      flags_q <= '0;
      resv_q  <= '0;
      sess_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      rcrc_q  <= '0;
    end else if (step_i) begin
      if (item_i.end_of_frame) begin
        pos_q   <= '0;
        crc_q   <= CRC_INIT;
        herr_q  <= ST_OK;
        type_q  <= '0;
        flags_q <= '0;
        resv_q  <= '0;
        sess_q  <= '0;
        idx_q   <= '0;
        cnt_q   <= '0;
        len_q   <= '0;
        rcrc_q  <= '0;
      end else begin
        pos_q   <= pos_d;
        crc_q   <= crc_d;
        herr_q  <= herr_d;
        type_q  <= type_d;
        flags_q <= flags_d;
        resv_q  <= resv_d;
        sess_q  <= sess_d;
        idx_q   <= idx_d;
        cnt_q   <= cnt_d;
        len_q   <= len_d;
        rcrc_q  <= rcrc_d;
      end
    end
  end

endmodule

FILE: rtl/fpc_out_stage.sv
// ---------------------------------------------------------------------------
// fpc_out_stage
// Result register: holds a result until the receiver takes it.
// ---------------------------------------------------------------------------
module fpc_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fpc_pkg::fpc_result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fpc_pkg::fpc_result_t res_o
);
  import fpc_pkg::*;

  logic        valid_q, valid_d;
  fpc_result_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/frame_parser_crc16_check_core.sv
// ---------------------------------------------------------------------------
// frame_parser_crc16_check_core
// Frame header parser with CRC-16/CCITT-FALSE check, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
// Input channel: one frame byte per transaction with an end-of-frame marker.
// Output channel: a forwarded payload byte (kind 0) for each payload byte of
// a frame whose header checked good, and one summary (kind 1) with the header
// fields and a status for the byte that carries end-of-frame.
// A taken byte moves from the input register through the parse logic into the
// result register. Throughput is one byte per cycle while the receiver does
// not stall, and the byte-wide CRC update is combinational.
// Reset clears the frame state, both stage valid flags and the configuration
// registers to their defaults; the first byte afterwards starts a new frame.
// When the receiver stalls, the result is held; at most one more byte is
// taken into the input register and then in_stall_o stays high until the
// result is taken.
// Write configuration only while no frame is in flight.
// ---------------------------------------------------------------------------
module frame_parser_crc16_check_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [7:0]  msg_type_o,
  output logic [7:0]  frame_flags_o,
  output logic [7:0]  reserved_byte_o,
  output logic [31:0] session_number_o,
  output logic [15:0] chunk_number_o,
  output logic [15:0] chunk_total_o,
  output logic [15:0] payload_size_o
);
  import fpc_pkg::*;

  fpc_cfg_t    cfg;
  fpc_item_t   item;
  fpc_result_t res_next;
  fpc_result_t res;
  logic        step;
  logic        free;
  logic        res_valid;

  fpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fpc_in_stage u_in (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .free_i         (free),
    .step_o         (step),
    .item_o         (item)
  );

  fpc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  fpc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_next),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Spread the result onto the output ports
  assign kind_o           = res.kind;
  assign payload_byte_o   = res.payload_byte;
  assign status_o         = res.status;
  assign msg_type_o       = res.msg_type;
  assign frame_flags_o    = res.frame_flags;
  assign reserved_byte_o  = res.reserved_byte;
  assign session_number_o = res.session_number;
  assign chunk_number_o   = res.chunk_number;
  assign chunk_total_o    = res.chunk_total;
  assign payload_size_o   = res.payload_size;

endmodule

FILE: rtl/fpc_checker.sv
// ---------------------------------------------------------------------------
// fpc_checker
// Port-level checks for the frame parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "frame_parser_crc16_check_core_defines.svh"

module fpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [2:0]  status_o,
  input logic [7:0]  msg_type_o,
  input logic [31:0] session_number_o
);
  import fpc_pkg::*;

  logic        held;
  logic [11:0] head;
  logic        pay_out;
  logic        hdr_clear;

  // Result blocked by the receiver, and the fields that must not move
  assign held      = out_valid_o && out_stall_i;
  assign head      = {kind_o, payload_byte_o, status_o};
  assign pay_out   = out_valid_o && !kind_o;
  assign hdr_clear = (status_o == ST_OK) && (msg_type_o == 8'd0) &&
                     (session_number_o == 32'd0);

  // Hold a stalled result
  `FPC_ASSERT(a_out_hold, clk_i, rst_ni, held |=> out_valid_o && $stable(head), "result not held")

  // Stall the input only behind a blocked result
  `FPC_ASSERT(a_in_stall_cause, clk_i, rst_ni, in_stall_o |-> held, "stall without blocked output")

  // Keep message type, session number and status zero on forwarded payload bytes
  `FPC_ASSERT(a_payload_zero, clk_i, rst_ni, pay_out |-> hdr_clear, "payload carries header data")

  // Drop the output while reset is held
  `FPC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind frame_parser_crc16_check_core fpc_checker u_fpc_checker (.*);
